// ===== hw/rtl/ttlm_pkg.sv =====
// package: shared types, constants and codes of the task timing and load monitor
`timescale 1ns / 1ps
`default_nettype none
package ttlm_pkg;
    localparam int TASK_SLOTS_DEF    = 4;
    localparam int LONG_WINDOWS_DEF  = 30;
    localparam int SHORT_WINDOWS_DEF = 10;
    localparam logic [31:0] WINDOW_US = 32'd1000000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REQ_START = 3'd0,
        REQ_END   = 3'd1,
        REQ_TICK  = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_READ  = 3'd4
    } req_t;

    localparam logic [2:0] REG_ACTIVE = 3'd0;
    localparam logic [2:0] REG_LIMIT0 = 3'd1;
    localparam logic [2:0] REG_LIMIT3 = 3'd4;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ttlm_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ttlm_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ttlm_pkg::div_req_t req,
    output ttlm_pkg::div_rsp_t      rsp
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] diff;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[63]};
        diff      = {1'b0, trial} - {2'b0, den_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[33]) begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/task_timing_load_monitor.sv =====
// top level: task timing and cpu load monitor with sequencer
//
// events enter on the s_ channel (valid/ready); one result item per event
// leaves on the m_ channel (valid/ready), drawn from the live state.
// start, end, read and unknown requests, and ticks that close no window, pass
// from ST_EXEC straight to ST_OUT. a clear walks the LONG_WINDOWS-entry (30 by
// default) history one entry a cycle. a tick that closes a window runs the shared
// 64-step divider for rate, load, up to four shares and two short averages and
// one long average, and walks the history rings twice.
// s_ready is low from acceptance until the result item is taken, so a
// stalled receiver holds the block; nothing is lost or repeated.
// reset (aresetn low, synchronous) clears all statistics and rings by a
// sweep of the LONG_WINDOWS ring entries (ST_INIT) during which no item is accepted;
// apb writes are taken at any time and land in the register file.
// apb: 0x00 active_tasks, 0x04..0x10 limit_task0..3, pready always high.
`timescale 1ns / 1ps
`default_nettype none
module task_timing_load_monitor #(
    parameter int TASK_SLOTS    = ttlm_pkg::TASK_SLOTS_DEF,
    parameter int LONG_WINDOWS  = ttlm_pkg::LONG_WINDOWS_DEF,
    parameter int SHORT_WINDOWS = ttlm_pkg::SHORT_WINDOWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [1:0]  s_task_slot,
    input  wire logic [31:0] s_now_us,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_task_last_us,
    output logic [31:0]      m_task_runs,
    output logic [31:0]      m_task_total_us,
    output logic [31:0]      m_task_min_us,
    output logic [31:0]      m_task_max_us,
    output logic [31:0]      m_task_overruns,
    output logic [6:0]       m_task_share,
    output logic [31:0]      m_loop_rate_hz,
    output logic [6:0]       m_load_pct,
    output logic [6:0]       m_load_avg_short,
    output logic [6:0]       m_load_avg_long,
    output logic [31:0]      m_rate_avg_short
);
    localparam int RW = (LONG_WINDOWS > 1) ? $clog2(LONG_WINDOWS) : 1;
    localparam int FW = $clog2(LONG_WINDOWS + 1);
    localparam logic [FW-1:0] LONG_F  = FW'(LONG_WINDOWS);
    localparam logic [FW-1:0] SHORT_F = FW'(SHORT_WINDOWS);
    localparam logic [RW-1:0] LAST_P  = RW'(LONG_WINDOWS - 1);
    localparam logic [2:0]    SLOTS3  = 3'(TASK_SLOTS);

    typedef enum logic [13:0] {
        ST_INIT   = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_EXEC   = 14'b00000000000100,
        ST_RATE   = 14'b00000000001000,
        ST_LOAD   = 14'b00000000010000,
        ST_SHARE  = 14'b00000000100000,
        ST_RING   = 14'b00000001000000,
        ST_SSUM   = 14'b00000010000000,
        ST_SDIV   = 14'b00000100000000,
        ST_SRDIV  = 14'b00001000000000,
        ST_LSUM   = 14'b00010000000000,
        ST_LDIV   = 14'b00100000000000,
        ST_CLEAR  = 14'b01000000000000,
        ST_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [2:0]  active_reg;
    logic [31:0] limit_reg [4];
    logic        wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            for (int i = 0; i < 4; i++) limit_reg[i] <= '0;
        end else if (wr_en) begin
            if (paddr[4:2] == ttlm_pkg::REG_ACTIVE) active_reg <= pwdata[2:0];
            else if (paddr[4:2] >= ttlm_pkg::REG_LIMIT0 && paddr[4:2] <= ttlm_pkg::REG_LIMIT3)
                limit_reg[2'(paddr[4:2] - ttlm_pkg::REG_LIMIT0)] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[4:2] == ttlm_pkg::REG_ACTIVE) prdata = {29'd0, active_reg};
        else if (paddr[4:2] >= ttlm_pkg::REG_LIMIT0 && paddr[4:2] <= ttlm_pkg::REG_LIMIT3)
            prdata = limit_reg[2'(paddr[4:2] - ttlm_pkg::REG_LIMIT0)];
    end

    // per-slot statistics, four entries each, fixed-place registers
    logic [31:0] stamp_reg [4];
    logic [31:0] runs_reg  [4];
    logic [31:0] total_reg [4];
    logic [31:0] min_reg   [4];
    logic [31:0] max_reg   [4];
    logic [31:0] last_reg  [4];
    logic [31:0] ovr_reg   [4];
    logic [6:0]  share_reg [4];

    // system state
    logic [31:0] busy_all_reg, wstart_reg, wticks_reg, wbusy_reg, rate_reg, len_reg;
    logic [6:0]  load_reg, avg_ls_reg, avg_ll_reg;
    logic [31:0] avg_rs_reg;
    logic [RW-1:0] pos_reg, idx_reg;
    logic [FW-1:0] fill_reg, cnt_reg, n_reg;
    logic [2:0]    k_reg;
    logic [37:0]   lsum_reg;
    logic [37:0]   rsum_reg;

    // latched item
    logic [2:0]  req_reg;
    logic [1:0]  slot_reg;
    logic [31:0] now_reg;
    logic        slot_ok_q;

    // history memories, one write port, one registered read port each
    logic [6:0]  load_mem [LONG_WINDOWS];
    logic [31:0] rate_mem [LONG_WINDOWS];
    logic        mem_we;
    logic [RW-1:0] mem_wa, mem_ra;
    logic [6:0]  mem_wl;
    logic [31:0] mem_wr;
    logic [6:0]  load_rd;
    logic [31:0] rate_rd;
    logic        rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            load_mem[mem_wa] <= mem_wl;
            rate_mem[mem_wa] <= mem_wr;
        end
        load_rd <= load_mem[mem_ra];
        rate_rd <= rate_mem[mem_ra];
    end

    // shared divider
    ttlm_pkg::div_req_t dreq;
    ttlm_pkg::div_rsp_t drsp;
    ttlm_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic        slot_ok;
    logic [2:0]  na;
    logic [31:0] el, wl;
    logic        accept;
    logic        div_wait_reg;
    assign slot_ok = {1'b0, s_task_slot} < SLOTS3;
    assign na      = (active_reg > SLOTS3) ? SLOTS3 : active_reg;
    assign el      = now_reg - stamp_reg[slot_reg];
    assign wl      = now_reg - wstart_reg;
    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign mem_ra  = idx_reg;

    always_comb begin
        state_next = state_reg;
        dreq       = '0;
        mem_we     = 1'b0;
        mem_wa     = pos_reg;
        mem_wl     = load_reg;
        mem_wr     = rate_reg;
        unique case (state_reg)
            ST_INIT: begin
                mem_we = 1'b1; mem_wa = idx_reg; mem_wl = '0; mem_wr = '0;
                if (idx_reg == LAST_P) state_next = ST_IDLE;
            end
            ST_IDLE:  if (accept) state_next = ST_EXEC;
            ST_EXEC: begin
                priority if (req_reg == ttlm_pkg::REQ_TICK && wl >= ttlm_pkg::WINDOW_US) begin
                    state_next = ST_RATE;
                    dreq.start = 1'b1;
                    // tick count including this tick
                    dreq.dividend = 64'(wticks_reg + 32'd1) * 64'(ttlm_pkg::WINDOW_US);
                    dreq.divisor = wl;
                end else if (req_reg == ttlm_pkg::REQ_CLEAR) state_next = ST_CLEAR;
                else state_next = ST_OUT;
            end
            ST_RATE: if (drsp.done) begin
                state_next = ST_LOAD;
                dreq.start = 1'b1;
                dreq.dividend = 64'(wbusy_reg) * 64'd100;
                dreq.divisor = len_reg;
            end
            ST_LOAD: if (drsp.done) state_next = ST_SHARE;
            ST_SHARE: begin
                if (!div_wait_reg) begin
                    if (k_reg >= na || wbusy_reg == '0 || busy_all_reg == '0)
                        state_next = ST_RING;
                    else begin
                        dreq.start = 1'b1;
                        dreq.dividend = 64'(total_reg[k_reg[1:0]]) * 64'd100;
                        dreq.divisor = busy_all_reg;
                    end
                end
            end
            ST_RING: begin
                mem_we = 1'b1;
                state_next = ST_SSUM;
            end
            ST_SSUM: if (cnt_reg == n_reg && !rd_vld_reg) begin
                state_next = ST_SDIV;
                dreq.start = 1'b1;
                dreq.dividend = 64'(lsum_reg);
                dreq.divisor = 32'(n_reg);
            end
            ST_SDIV: if (drsp.done) begin
                state_next = ST_SRDIV;
                dreq.start = 1'b1;
                dreq.dividend = 64'(rsum_reg);
                dreq.divisor = 32'(n_reg);
            end
            ST_SRDIV: if (drsp.done) state_next = ST_LSUM;
            ST_LSUM: if (cnt_reg == fill_reg && !rd_vld_reg) begin
                state_next = ST_LDIV;
                dreq.start = 1'b1;
                dreq.dividend = 64'(lsum_reg);
                dreq.divisor = 32'(fill_reg);
            end
            ST_LDIV: if (drsp.done) state_next = ST_OUT;
            ST_CLEAR: begin
                mem_we = 1'b1; mem_wa = idx_reg; mem_wl = '0; mem_wr = '0;
                if (idx_reg == LAST_P) state_next = ST_OUT;
            end
            ST_OUT: if (m_valid && m_ready) state_next = ST_IDLE;
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            m_valid      <= 1'b0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            div_wait_reg <= 1'b0;
            busy_all_reg <= '0; wstart_reg <= '0; wticks_reg <= '0; wbusy_reg <= '0;
            rate_reg <= '0; load_reg <= '0;
            avg_ls_reg <= '0; avg_ll_reg <= '0; avg_rs_reg <= '0;
            pos_reg <= '0; fill_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                stamp_reg[i] <= '0; runs_reg[i] <= '0; total_reg[i] <= '0;
                min_reg[i] <= ttlm_pkg::ALL_ONES; max_reg[i] <= '0; last_reg[i] <= '0;
                ovr_reg[i] <= '0; share_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_INIT: idx_reg <= (idx_reg == LAST_P) ? '0 : idx_reg + 1'b1;
                ST_IDLE: if (accept) begin
                    req_reg  <= s_req_type;
                    slot_reg <= s_task_slot;
                    now_reg  <= s_now_us;
                    slot_ok_q <= slot_ok;
                end
                ST_EXEC: begin
                    k_reg <= '0;
                    idx_reg <= '0;
                    len_reg <= wl;
                    div_wait_reg <= 1'b0;
                    priority case (req_reg)
                        ttlm_pkg::REQ_START: if (slot_ok_q) stamp_reg[slot_reg] <= now_reg;
                        ttlm_pkg::REQ_END: if (slot_ok_q) begin
                            runs_reg[slot_reg]  <= runs_reg[slot_reg] + 32'd1;
                            total_reg[slot_reg] <= total_reg[slot_reg] + el;
                            last_reg[slot_reg]  <= el;
                            if (el < min_reg[slot_reg]) min_reg[slot_reg] <= el;
                            if (el > max_reg[slot_reg]) max_reg[slot_reg] <= el;
                            if (limit_reg[slot_reg] != '0 && el > limit_reg[slot_reg])
                                ovr_reg[slot_reg] <= ovr_reg[slot_reg] + 32'd1;
                            busy_all_reg <= busy_all_reg + el;
                            wbusy_reg    <= wbusy_reg + el;
                        end
                        ttlm_pkg::REQ_TICK: begin
                            wticks_reg <= wticks_reg + 32'd1;
                            if (wbusy_reg > wl && wl >= ttlm_pkg::WINDOW_US) wbusy_reg <= wl;
                        end
                        ttlm_pkg::REQ_CLEAR: begin
                            for (int i = 0; i < 4; i++) if (3'(i) < na) begin
                                runs_reg[i] <= '0; total_reg[i] <= '0;
                                min_reg[i] <= ttlm_pkg::ALL_ONES; max_reg[i] <= '0;
                                last_reg[i] <= '0; ovr_reg[i] <= '0; share_reg[i] <= '0;
                            end
                            busy_all_reg <= '0; rate_reg <= '0; load_reg <= '0;
                            avg_ls_reg <= '0; avg_ll_reg <= '0; avg_rs_reg <= '0;
                            wstart_reg <= now_reg; wticks_reg <= '0; wbusy_reg <= '0;
                            pos_reg <= '0; fill_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_RATE: if (drsp.done) rate_reg <= drsp.quotient[31:0];
                ST_LOAD: if (drsp.done) load_reg <= drsp.quotient[6:0];
                ST_SHARE: begin
                    if (div_wait_reg) begin
                        if (drsp.done) begin
                            share_reg[k_reg[1:0]] <= (drsp.quotient > 64'd100) ? 7'd100
                                                     : drsp.quotient[6:0];
                            k_reg <= k_reg + 3'd1;
                            div_wait_reg <= 1'b0;
                        end
                    end else if (dreq.start) div_wait_reg <= 1'b1;
                end
                ST_RING: begin
                    pos_reg  <= (pos_reg == LAST_P) ? '0 : pos_reg + 1'b1;
                    if (fill_reg < LONG_F) fill_reg <= fill_reg + 1'b1;
                    n_reg    <= ((fill_reg < LONG_F ? fill_reg + 1'b1 : fill_reg) < SHORT_F)
                                ? (fill_reg < LONG_F ? fill_reg + 1'b1 : fill_reg) : SHORT_F;
                    idx_reg  <= pos_reg;
                    cnt_reg  <= '0;
                    lsum_reg <= '0;
                    rsum_reg <= '0;
                    rd_vld_reg <= 1'b0;
                end
                ST_SSUM: begin
                    // issue a read per entry, add it in the next cycle
                    if (rd_vld_reg) begin
                        lsum_reg <= lsum_reg + 38'(load_rd);
                        rsum_reg <= rsum_reg + 38'(rate_rd);
                    end
                    if (cnt_reg != n_reg) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                        idx_reg <= (idx_reg == '0) ? LAST_P : idx_reg - 1'b1;
                    end else rd_vld_reg <= 1'b0;
                end
                ST_SDIV: if (drsp.done) avg_ls_reg <= drsp.quotient[6:0];
                ST_SRDIV: if (drsp.done) begin
                    avg_rs_reg <= drsp.quotient[31:0];
                    idx_reg <= '0; cnt_reg <= '0; lsum_reg <= '0; rd_vld_reg <= 1'b0;
                end
                ST_LSUM: begin
                    // entry cnt is read now, the next address is set up for the following read
                    if (rd_vld_reg) lsum_reg <= lsum_reg + 38'(load_rd);
                    if (cnt_reg != fill_reg) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                        idx_reg <= RW'(cnt_reg + 1'b1);
                    end else rd_vld_reg <= 1'b0;
                end
                ST_LDIV: if (drsp.done) begin
                    avg_ll_reg <= drsp.quotient[6:0];
                    wstart_reg <= now_reg; wticks_reg <= '0; wbusy_reg <= '0;
                end
                ST_CLEAR: idx_reg <= (idx_reg == LAST_P) ? '0 : idx_reg + 1'b1;
                ST_OUT: ;
                default: ;
            endcase
            // valid register, set as the state machine enters ST_OUT
            if (state_next == ST_OUT && state_reg != ST_OUT) m_valid <= 1'b1;
            else if (m_valid && m_ready) m_valid <= 1'b0;
        end
    end

    // result drawn from the live state, which holds still while m_valid is high
    always_comb begin
        if (slot_ok_q) begin
            m_task_last_us  = last_reg[slot_reg];
            m_task_runs     = runs_reg[slot_reg];
            m_task_total_us = total_reg[slot_reg];
            m_task_min_us   = min_reg[slot_reg];
            m_task_max_us   = max_reg[slot_reg];
            m_task_overruns = ovr_reg[slot_reg];
            m_task_share    = share_reg[slot_reg];
        end else begin
            m_task_last_us = '0; m_task_runs = '0; m_task_total_us = '0;
            m_task_min_us = '0; m_task_max_us = '0; m_task_overruns = '0;
            m_task_share = '0;
        end
    end
    assign m_loop_rate_hz   = rate_reg;
    assign m_load_pct       = load_reg;
    assign m_load_avg_short = avg_ls_reg;
    assign m_load_avg_long  = avg_ll_reg;
    assign m_rate_avg_short = avg_rs_reg;

    // only idle takes items, only the output state shows results
    assert property (@(posedge aclk) disable iff (!aresetn) s_ready |-> !m_valid)
        else $error("ready while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_task_runs)))
        else $error("result changed under stall");
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> load_reg <= 7'd100)
        else $error("load above 100");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LONG_F) else $error("fill overrun");
endmodule
`default_nettype wire
